// ===== rtl/priority_ready_queue_defines.svh =====
// ----------------------------------------------------------------------------
// priority_ready_queue_defines
// Assertion macros used by the ready queue RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PRQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Types and constants for the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int PRIO_W      = 8;
    localparam int OCC_W       = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    // command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_cell_cmd;

    localparam t_slot SLOT_EMPTY = '{valid: 1'b0, id: '0, prio: '0};

endpackage

// ===== rtl/prq_cell.sv =====
// ----------------------------------------------------------------------------
// prq_cell
// One queue slot: keeps its entry, takes the new word, or takes a neighbor's.
// ----------------------------------------------------------------------------
module prq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prq_pkg::t_cell_cmd i_cmd,
    input  prq_pkg::t_slot    i_prev,
    input  logic              i_prev_stay,
    input  prq_pkg::t_slot    i_next,
    output prq_pkg::t_slot    o_slot,
    output logic              o_stay
);
    import prq_pkg::*;

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    t_slot             n_slot;

    assign o_slot = '{valid: r_valid, id: r_id, prio: r_prio};
    // entry outranks or ties the incoming one: it stays ahead
    assign o_stay = r_valid && (r_prio >= i_cmd.prio);

    always_comb begin
        n_slot = o_slot;
        if (i_cmd.ins) begin
            if (!o_stay) begin
                if (i_prev_stay) begin
                    n_slot = '{valid: 1'b1, id: i_cmd.id, prio: i_cmd.prio};
                end else begin
                    n_slot = i_prev;
                end
            end
        end else if (i_cmd.rem) begin
            n_slot = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_slot.id;
        r_prio <= n_slot.prio;
    end

endmodule

// ===== rtl/prq_row.sv =====
// ----------------------------------------------------------------------------
// prq_row
// Row of slot cells, head at cell 0, sorted by descending priority.
// ----------------------------------------------------------------------------
module prq_row (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  prq_pkg::t_cell_cmd                 i_cmd,
    output prq_pkg::t_slot                     o_head,
    output logic                               o_full,
    output logic [prq_pkg::QUEUE_DEPTH-1:0]    o_valid_vec
);
    import prq_pkg::*;

    t_slot w_slot [QUEUE_DEPTH];
    logic  w_stay [QUEUE_DEPTH];

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot w_prev;
        t_slot w_next;
        logic  w_prev_stay;

        if (g == 0) begin : g_first
            assign w_prev      = SLOT_EMPTY;
            assign w_prev_stay = 1'b1;
        end else begin : g_mid
            assign w_prev      = w_slot[g-1];
            assign w_prev_stay = w_stay[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = SLOT_EMPTY;
        end else begin : g_body
            assign w_next = w_slot[g+1];
        end

        prq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (i_cmd),
            .i_prev      (w_prev),
            .i_prev_stay (w_prev_stay),
            .i_next      (w_next),
            .o_slot      (w_slot[g]),
            .o_stay      (w_stay[g])
        );

        assign o_valid_vec[g] = w_slot[g].valid;
    end

    assign o_head = w_slot[0];
    assign o_full = w_slot[QUEUE_DEPTH-1].valid;

endmodule

// ===== rtl/priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue
// Bounded ready queue: inserts by descending priority (FIFO on ties),
// removes the head, one result word per input word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  input   | in        | i_valid / o_stall   | i_func, i_task_id, i_prio
//  result  | out       | o_valid / i_stall   | o_out_task_id, o_out_prio,
//          |           |                     | o_status, o_occupancy
//
// One word per cycle while the input is not stalled; its result appears the cycle after it is taken.
// Every cell compares and shifts in that same cycle, whatever the depth.
// Synchronous reset empties the queue; no clearing pass is needed.
// Input stalls only while a result is held and the output side stalls.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_defines.svh"

module priority_ready_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_func,
    input  logic [prq_pkg::ID_W-1:0]    i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0]  i_prio,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [prq_pkg::ID_W-1:0]    o_out_task_id,
    output logic [prq_pkg::PRIO_W-1:0]  o_out_prio,
    output logic [1:0]                  o_status,
    output logic [prq_pkg::OCC_W-1:0]   o_occupancy
);
    import prq_pkg::*;

    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    logic [PRIO_W-1:0] r_out_prio;
    t_status           r_status;
    logic [FILL_W-1:0] r_fill;

    logic              n_out_valid;
    logic [ID_W-1:0]   n_out_id;
    logic [PRIO_W-1:0] n_out_prio;
    t_status           n_status;
    logic [FILL_W-1:0] n_fill;

    logic                   w_accept;
    t_cell_cmd              w_cmd;
    t_slot                  w_head;
    logic                   w_full;
    logic [QUEUE_DEPTH-1:0] w_valid_vec;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    prq_row u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_head      (w_head),
        .o_full      (w_full),
        .o_valid_vec (w_valid_vec)
    );

    always_comb begin
        w_cmd.ins   = w_accept && (i_func == FUNC_INSERT) && !w_full;
        w_cmd.rem   = w_accept && (i_func == FUNC_REMOVE) && w_head.valid;
        w_cmd.id    = i_task_id;
        w_cmd.prio  = i_prio;

        n_out_valid = r_out_valid && i_stall;
        n_out_id    = r_out_id;
        n_out_prio  = r_out_prio;
        n_status    = r_status;
        n_fill      = r_fill;

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_id    = '0;
            n_out_prio  = '0;
            n_status    = ST_OK;
            if (i_func == FUNC_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end else if (!w_head.valid) begin
                n_status = ST_EMPTY;
            end else begin
                n_out_id   = w_head.id;
                n_out_prio = w_head.prio;
                n_fill     = r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_id   <= n_out_id;
        r_out_prio <= n_out_prio;
        r_status   <= n_status;
    end

    assign o_valid       = r_out_valid;
    assign o_out_task_id = r_out_id;
    assign o_out_prio    = r_out_prio;
    assign o_status      = r_status;
    // occupancy of the word in the output register
    logic [FILL_W-1:0] r_occ;
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_occ <= n_fill;
        end
    end
    assign o_occupancy = OCC_W'(r_occ);

    `PRQ_ASSERT_IMP(a_fill_matches_cells, 1'b1, r_fill == FILL_W'($countones(w_valid_vec)), "fill count disagrees with cell valid bits")
    `PRQ_ASSERT_IMP(a_full_at_depth, w_full, r_fill == FILL_W'(QUEUE_DEPTH), "last cell valid below depth")
    `PRQ_ASSERT_NXT(a_empty_status, w_accept && (i_func == FUNC_REMOVE) && !w_head.valid, o_valid && (r_status == ST_EMPTY) && (r_out_id == '0), "remove on empty not reported")
    `PRQ_ASSERT_NXT(a_insert_grows, w_cmd.ins, r_fill == $past(r_fill) + FILL_W'(1), "insert did not grow the queue")

endmodule
